FILE: rtl/rgbed_pkg.sv
package rgbed_pkg;

    localparam int PIX_W  = 8;
    localparam int SQ_W   = 2 * PIX_W;
    localparam int OPND_W = SQ_W + 2;
    localparam int ROOT_W = OPND_W / 2;
    localparam int OUT_W  = 32;

    // Highest even weight of the square-root operand
    localparam logic [OPND_W-1:0] TOP_BIT = OPND_W'(1) << (OPND_W - 2);

    typedef struct packed {
        logic [OPND_W-1:0] rem;
        logic [OPND_W-1:0] root;
        logic [OPND_W-1:0] bit_w;
        logic              frame_end;
    } sqrt_data_t;

endpackage

FILE: rtl/rgb_euclid_distance_sum.sv
// Stages: the input transfer loads the square stage; 9 square-root digit cells and the
// accumulate/output register follow, and the last of these presents total_distance.
// Throughput: one pixel pair per cycle while the chain is not stalled; each cell settles one root bit and passes on.
// A waiting frame total stalls the chain only when the next frame end reaches it.
// Reset (rst_n low, asynchronous) empties every stage and clears the running sum.
module rgb_euclid_distance_sum
    import rgbed_pkg::*;
#(
    parameter int SUM_BITS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] ref_red,
    input  logic [PIX_W-1:0] ref_green,
    input  logic [PIX_W-1:0] ref_blue,
    input  logic [PIX_W-1:0] cand_red,
    input  logic [PIX_W-1:0] cand_green,
    input  logic [PIX_W-1:0] cand_blue,
    input  logic             frame_end,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] total_distance
);

    sqrt_data_t chain_data  [ROOT_W+1];
    logic       chain_valid [ROOT_W+1];
    logic       chain_ready [ROOT_W+1];

    rgbed_sqdiff u_sqdiff (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ref_red    (ref_red),
        .ref_green  (ref_green),
        .ref_blue   (ref_blue),
        .cand_red   (cand_red),
        .cand_green (cand_green),
        .cand_blue  (cand_blue),
        .frame_end  (frame_end),
        .dn_valid   (chain_valid[0]),
        .dn_ready   (chain_ready[0]),
        .dn_data    (chain_data[0])
    );

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        rgbed_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_data  (chain_data[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_data  (chain_data[i+1])
        );
    end

    rgbed_accum #(
        .SUM_BITS (SUM_BITS)
    ) u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (chain_valid[ROOT_W]),
        .in_ready       (chain_ready[ROOT_W]),
        .pair_root      (chain_data[ROOT_W].root[ROOT_W-1:0]),
        .frame_end      (chain_data[ROOT_W].frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .total_distance (total_distance)
    );

endmodule

FILE: rtl/rgbed_sqdiff.sv
module rgbed_sqdiff
    import rgbed_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] ref_red,
    input  logic [PIX_W-1:0] ref_green,
    input  logic [PIX_W-1:0] ref_blue,
    input  logic [PIX_W-1:0] cand_red,
    input  logic [PIX_W-1:0] cand_green,
    input  logic [PIX_W-1:0] cand_blue,
    input  logic             frame_end,
    output logic             dn_valid,
    input  logic             dn_ready,
    output sqrt_data_t       dn_data
);

    logic       valid_reg;
    sqrt_data_t data_reg;
    sqrt_data_t data_next;
    logic [PIX_W-1:0] d_r;
    logic [PIX_W-1:0] d_g;
    logic [PIX_W-1:0] d_b;
    logic [SQ_W-1:0]  sq_r;
    logic [SQ_W-1:0]  sq_g;
    logic [SQ_W-1:0]  sq_b;

    assign in_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        d_r  = (ref_red   >= cand_red)   ? ref_red   - cand_red   : cand_red   - ref_red;
        d_g  = (ref_green >= cand_green) ? ref_green - cand_green : cand_green - ref_green;
        d_b  = (ref_blue  >= cand_blue)  ? ref_blue  - cand_blue  : cand_blue  - ref_blue;
        sq_r = SQ_W'(d_r) * SQ_W'(d_r);
        sq_g = SQ_W'(d_g) * SQ_W'(d_g);
        sq_b = SQ_W'(d_b) * SQ_W'(d_b);
        data_next.rem       = OPND_W'(sq_r) + OPND_W'(sq_g) + OPND_W'(sq_b);
        data_next.root      = '0;
        data_next.bit_w     = TOP_BIT;
        data_next.frame_end = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/rgbed_sqrt_cell.sv
module rgbed_sqrt_cell
    import rgbed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  sqrt_data_t up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output sqrt_data_t dn_data
);

    logic              valid_reg;
    sqrt_data_t        data_reg;
    sqrt_data_t        data_next;
    logic [OPND_W:0]   trial;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // One root digit: subtract root + bit when it fits
    always_comb
    begin
        trial               = {1'b0, up_data.root} + {1'b0, up_data.bit_w};
        data_next.frame_end = up_data.frame_end;
        data_next.bit_w     = up_data.bit_w >> 2;
        if ({1'b0, up_data.rem} >= trial)
        begin
            data_next.rem  = up_data.rem - trial[OPND_W-1:0];
            data_next.root = (up_data.root >> 1) + up_data.bit_w;
        end
        else
        begin
            data_next.rem  = up_data.rem;
            data_next.root = up_data.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/rgbed_accum.sv
module rgbed_accum
    import rgbed_pkg::*;
#(
    parameter int SUM_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ROOT_W-1:0] pair_root,
    input  logic              frame_end,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  total_distance
);

    logic [SUM_BITS-1:0] sum_reg;
    logic [SUM_BITS-1:0] sum_next;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    total_reg;
    logic                take;

    // Hold a frame total back only while the previous one waits
    assign in_ready       = !frame_end || !out_valid_reg || out_ready;
    assign take           = in_valid && in_ready;
    assign sum_next       = sum_reg + SUM_BITS'(pair_root);
    assign out_valid      = out_valid_reg;
    assign total_distance = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && frame_end)
            begin
                sum_reg       <= '0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (take)
                begin
                    sum_reg <= sum_next;
                end
                if (out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && frame_end)
        begin
            total_reg <= OUT_W'(sum_next);
        end
    end

`ifndef ASSERT_OFF
    a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        take && frame_end |=> sum_reg == '0)
        else $error("accumulator not cleared after frame end");

    a_result_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        take && frame_end |=> out_valid_reg)
        else $error("frame total not presented");

    a_hold_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(total_reg))
        else $error("waiting frame total changed");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && frame_end |-> !in_ready)
        else $error("frame total overwritten while waiting");
`endif

endmodule

FILE: verif/tb_rgb_euclid_distance_sum.sv
`timescale 1ns / 1ps

module tb_rgb_euclid_distance_sum;
    import rgbed_pkg::*;

    localparam int SUM_BITS     = 32;
    localparam int N_DIRECTED   = 20;
    localparam int N_RANDOM     = 600;
    localparam int PHASE_LEN    = 210;
    localparam int HOLD_AT      = 470;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_A      = N_DIRECTED;
    localparam int DRAIN_B      = 350;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 30;

    typedef struct {
        logic [PIX_W-1:0] ref_r;
        logic [PIX_W-1:0] ref_g;
        logic [PIX_W-1:0] ref_b;
        logic [PIX_W-1:0] cand_r;
        logic [PIX_W-1:0] cand_g;
        logic [PIX_W-1:0] cand_b;
        logic             last;
        bit               wait_drain;
    } pixel_pair_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [PIX_W-1:0] ref_red = '0;
    logic [PIX_W-1:0] ref_green = '0;
    logic [PIX_W-1:0] ref_blue = '0;
    logic [PIX_W-1:0] cand_red = '0;
    logic [PIX_W-1:0] cand_green = '0;
    logic [PIX_W-1:0] cand_blue = '0;
    logic             frame_end = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [OUT_W-1:0] total_distance;

    pixel_pair_t          pending_pairs[$];
    pixel_pair_t          cur_pair;
    logic [OUT_W-1:0]     frame_totals[$];
    logic [SUM_BITS-1:0]  frame_sum = '0;
    logic [OUT_W-1:0]     want_total;
    int                   n_acc = 0;
    int                   n_frames = 0;
    int                   n_checked = 0;
    int                   n_err = 0;
    int                   max_dist = 0;
    int                   stall_left;
    bit                   hold_done;

    rgb_euclid_distance_sum #(.SUM_BITS(SUM_BITS)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .ref_red        (ref_red),
        .ref_green      (ref_green),
        .ref_blue       (ref_blue),
        .cand_red       (cand_red),
        .cand_green     (cand_green),
        .cand_blue      (cand_blue),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .total_distance (total_distance)
    );

    always #2 clk = ~clk;

    function automatic logic [SQ_W-1:0] sq_delta(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        d = (a >= b) ? a - b : b - a;
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    // Build the root one bit at a time from the top, keeping each bit whose square still fits.
    function automatic logic [ROOT_W-1:0] floor_root(input logic [OPND_W-1:0] v);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] trial;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = r | (ROOT_W'(1) << b);
            if (OPND_W'(trial) * OPND_W'(trial) <= v)
                r = trial;
        end
        return r;
    endfunction

    task automatic absorb_pair(input pixel_pair_t p);
        logic [OPND_W-1:0] ss;
        logic [ROOT_W-1:0] pair_dist;
        ss = OPND_W'(sq_delta(p.ref_r, p.cand_r)) + OPND_W'(sq_delta(p.ref_g, p.cand_g))
             + OPND_W'(sq_delta(p.ref_b, p.cand_b));
        pair_dist = floor_root(ss);
        if (int'(pair_dist) > max_dist)
            max_dist = int'(pair_dist);
        frame_sum = frame_sum + SUM_BITS'(pair_dist);
        if (p.last)
        begin
            frame_totals.push_back(frame_sum[OUT_W-1:0]);
            frame_sum = '0;
            n_frames++;
        end
    endtask

    task automatic add_pair(input logic [PIX_W-1:0] rr, input logic [PIX_W-1:0] rg,
                            input logic [PIX_W-1:0] rb, input logic [PIX_W-1:0] cr,
                            input logic [PIX_W-1:0] cg, input logic [PIX_W-1:0] cb,
                            input logic last);
        pixel_pair_t p;
        p.ref_r = rr;
        p.ref_g = rg;
        p.ref_b = rb;
        p.cand_r = cr;
        p.cand_g = cg;
        p.cand_b = cb;
        p.last = last;
        p.wait_drain = (pending_pairs.size() == DRAIN_A) || (pending_pairs.size() == DRAIN_B);
        pending_pairs.push_back(p);
    endtask

    task automatic add_random_pair(input logic last);
        logic [PIX_W-1:0] c[6];
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 6; i++)
            c[i] = PIX_W'($urandom_range(255));
        if (kind == 0)
        begin
            for (int i = 0; i < 6; i++)
                c[i] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        else if (kind == 1)
        begin
            for (int i = 0; i < 3; i++)
                c[i+3] = c[i];
        end
        else if (kind == 2)
        begin
            for (int i = 0; i < 3; i++)
                c[i+3] = c[i] ^ PIX_W'($urandom_range(7));
        end
        add_pair(c[0], c[1], c[2], c[3], c[4], c[5], last);
    endtask

    function automatic int send_idle_pct();
        if (n_acc < PHASE_LEN)
            return 26;
        else if (n_acc < 2 * PHASE_LEN)
            return 62;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (n_acc < PHASE_LEN)
            return 62;
        else if (n_acc < 2 * PHASE_LEN)
            return 26;
        return 0;
    endfunction

    // Sender: predict on each transfer, then offer the next pair or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_pair(cur_pair);
                n_acc++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_pairs.size() != 0
                    && !(pending_pairs[0].wait_drain && frame_totals.size() != 0)
                    && $urandom_range(99) >= send_idle_pct())
                begin
                    cur_pair = pending_pairs.pop_front();
                    ref_red    <= cur_pair.ref_r;
                    ref_green  <= cur_pair.ref_g;
                    ref_blue   <= cur_pair.ref_b;
                    cand_red   <= cur_pair.cand_r;
                    cand_green <= cur_pair.cand_g;
                    cand_blue  <= cur_pair.cand_b;
                    frame_end  <= cur_pair.last;
                    in_valid   <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off while the sender keeps streaming.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_acc >= HOLD_AT)
        begin
            stall_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_totals.size() == 0)
                begin
                    $display("%0t ERROR: total_distance expected none, got %0d",
                             $time, total_distance);
                    n_err++;
                end
                else
                begin
                    want_total = frame_totals.pop_front();
                    if (total_distance !== want_total)
                    begin
                        $display("%0t ERROR: total_distance expected %0d, got %0d",
                                 $time, want_total, total_distance);
                        n_err++;
                    end
                    n_checked++;
                end
            end
            out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct());
        end
    end

    initial
    begin
        int flen;
        int guard;
        // Single-pair frames: zero distance, then the largest one in both directions.
        add_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        add_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
        add_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // One channel at a time, then exact squares, alternating bit patterns and mixed pairs.
        add_pair(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pair(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pair(8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
        add_pair(8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pair(8'h00, 8'h00, 8'h0C, 8'h03, 8'h04, 8'h00, 1'b0);
        add_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
        add_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1);
        add_pair(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
        add_pair(8'h80, 8'h7F, 8'h01, 8'h7F, 8'h80, 8'hFE, 1'b0);
        add_pair(8'h12, 8'h34, 8'h56, 8'h12, 8'h34, 8'h56, 1'b1);
        add_pair(8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1);
        add_pair(8'h02, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pair(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
        add_pair(8'hFF, 8'hFE, 8'hFD, 8'h00, 8'h01, 8'h02, 1'b0);
        add_pair(8'h0F, 8'hF0, 8'h3C, 8'hF0, 8'h0F, 8'hC3, 1'b1);
        // Random frames, mostly short, some of a single pair.
        while (pending_pairs.size() < N_DIRECTED + N_RANDOM)
        begin
            flen = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 14);
            for (int k = 0; k < flen; k++)
                add_random_pair(k == flen - 1);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || in_valid)
            @(posedge clk);
        guard = 0;
        while (frame_totals.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (frame_totals.size() != 0)
        begin
            $display("%0t ERROR: %0d frame totals never arrived", $time, frame_totals.size());
            n_err++;
        end

        $display("Streamed %0d pixel pairs in %0d frames, %0d totals checked",
                 n_acc, n_frames, n_checked);
        $display("Largest pair distance %0d; sender and receiver idling, long output stall",
                 max_dist);
        if (n_err == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rgbed_pkg.sv
rtl/rgbed_sqdiff.sv
rtl/rgbed_sqrt_cell.sv
rtl/rgbed_accum.sv
rtl/rgb_euclid_distance_sum.sv
verif/tb_rgb_euclid_distance_sum.sv
